// File: rtl/assert_macros.svh
// Assertion macros used by the LFU cache table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/lfu_pkg.sv
// Types and codes of the LFU cache table
package lfu_pkg;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    localparam logic [1:0] OP_NONE      = 2'd0;
    localparam logic [1:0] OP_HIT       = 2'd1;
    localparam logic [1:0] OP_INS_FREE  = 2'd2;
    localparam logic [1:0] OP_INS_EVICT = 2'd3;

    typedef struct packed {
        logic               action;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } rsp_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] count;
    } rec_t;

    typedef struct packed {
        logic match_found;
        logic vic_found;
        logic free_found;
    } scan_flags_t;

endpackage

// File: rtl/lfu_store.sv
// Slot memory: records, recency ranks and valid bits, registered read
module lfu_store #(
    parameter int CAPACITY = 16,
    parameter int IW = 4,
    parameter int RW = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  logic [IW-1:0]  rd_idx,
    output lfu_pkg::rec_t  rd_rec,
    output logic [RW-1:0]  rd_rank,
    output logic           rd_valid,
    input  logic           wr_en,
    input  logic [IW-1:0]  wr_idx,
    input  lfu_pkg::rec_t  wr_rec,
    input  logic [RW-1:0]  wr_rank,
    input  logic           wr_set_valid
);
    import lfu_pkg::*;

    rec_t          rec_mem [CAPACITY];
    logic [RW-1:0] rank_mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    rec_t          rd_rec_reg;
    logic [RW-1:0] rd_rank_reg;
    logic          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wr_idx]  <= wr_rec;
            rank_mem[wr_idx] <= wr_rank;
        end
        if (rd_en)
        begin
            rd_rec_reg  <= rec_mem[rd_idx];
            rd_rank_reg <= rank_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_set_valid)
                valid_reg[wr_idx] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd_rec   = rd_rec_reg;
    assign rd_rank  = rd_rank_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// File: rtl/lfu_scan.sv
// Per-slot compare unit: key match, eviction victim and first free slot
module lfu_scan #(
    parameter int IW = 4,
    parameter int RW = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clr,
    input  logic                 en,
    input  logic [IW-1:0]        slot_idx,
    input  logic                 slot_valid,
    input  lfu_pkg::rec_t        slot_rec,
    input  logic [RW-1:0]        slot_rank,
    input  logic [31:0]          key,
    output lfu_pkg::scan_flags_t flags,
    output logic [IW-1:0]        match_idx,
    output logic [31:0]          match_value,
    output logic [RW-1:0]        match_rank,
    output logic [IW-1:0]        vic_idx,
    output logic [RW-1:0]        vic_rank,
    output logic [IW-1:0]        free_idx
);
    import lfu_pkg::*;

    scan_flags_t   flags_reg;
    logic [IW-1:0] match_idx_reg;
    logic [31:0]   match_value_reg;
    logic [RW-1:0] match_rank_reg;
    logic [IW-1:0] vic_idx_reg;
    logic [31:0]   vic_count_reg;
    logic [RW-1:0] vic_rank_reg;
    logic [IW-1:0] free_idx_reg;
    logic          take_match;
    logic          take_vic;
    logic          take_free;

    always_comb
    begin
        take_match = en && slot_valid && !flags_reg.match_found && (slot_rec.key == key);
        take_vic   = en && slot_valid && (!flags_reg.vic_found ||
                     (slot_rec.count < vic_count_reg) ||
                     ((slot_rec.count == vic_count_reg) && (slot_rank > vic_rank_reg)));
        take_free  = en && !slot_valid && !flags_reg.free_found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else if (clr)
            flags_reg <= '0;
        else
        begin
            if (take_match)
                flags_reg.match_found <= 1'b1;
            if (take_vic)
                flags_reg.vic_found <= 1'b1;
            if (take_free)
                flags_reg.free_found <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_match)
        begin
            match_idx_reg   <= slot_idx;
            match_value_reg <= slot_rec.value;
            match_rank_reg  <= slot_rank;
        end
        if (take_vic)
        begin
            vic_idx_reg   <= slot_idx;
            vic_count_reg <= slot_rec.count;
            vic_rank_reg  <= slot_rank;
        end
        if (take_free)
            free_idx_reg <= slot_idx;
    end

    assign flags       = flags_reg;
    assign match_idx   = match_idx_reg;
    assign match_value = match_value_reg;
    assign match_rank  = match_rank_reg;
    assign vic_idx     = vic_idx_reg;
    assign vic_rank    = vic_rank_reg;
    assign free_idx    = free_idx_reg;

endmodule

// File: rtl/lfu_cache_table.sv
// LFU cache table: top level with sequencer and slot update logic
//
//  channel  signals                      direction  accepted when
//  command  start, busy, cmd             in         start & !busy
//  result   res_valid, res               out        res_valid (one cycle)
//  config   cfg_valid, cfg_ready, cfg_data  in      cfg_valid & cfg_ready
//
// A get or set sweeps all CAPACITY slots through the compare unit, one slot a
// cycle from the slot memory's read port, then decides. A hit or insert makes a
// second sweep, one read-modify-write a cycle, to fix ranks and the target slot.
// busy: held through the scan, the decision and, for a hit or insert, the update sweep.
// A get result is registered from the decide state; it cannot be stalled.
// Reset clears all valid bits at once; no clearing pass.
`include "assert_macros.svh"

module lfu_cache_table #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lfu_pkg::req_t cmd,
    output logic          res_valid,
    output lfu_pkg::rsp_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data
);
    import lfu_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = IW;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > 5) ? FW : 5;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_MAX  = CW'(CAPACITY);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_SCAN_END = 3'd2;
    localparam logic [2:0] ST_DECIDE   = 3'd3;
    localparam logic [2:0] ST_UPD      = 3'd4;
    localparam logic [2:0] ST_UPD_END  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          lag_en_reg;
    logic [IW-1:0] lag_idx_reg;
    req_t          cmd_reg;
    logic [4:0]    capacity_reg;
    logic [FW-1:0] filled_reg;
    logic [1:0]    op_reg, op_next;
    logic [IW-1:0] target_reg, target_next;
    logic [RW-1:0] ref_rank_reg, ref_rank_next;
    logic          res_valid_reg;
    rsp_t          res_reg;

    logic          accept;
    logic          rd_en;
    rec_t          rd_rec;
    logic [RW-1:0] rd_rank;
    logic          rd_valid;
    logic          wr_en;
    rec_t          wr_rec;
    logic [RW-1:0] wr_rank;
    logic          wr_set_valid;
    logic          scan_en;
    logic          upd_phase;
    logic [CW-1:0] cap_eff;
    logic [CW-1:0] filled_wide;

    scan_flags_t   flags;
    logic [IW-1:0] match_idx;
    logic [31:0]   match_value;
    logic [RW-1:0] match_rank;
    logic [IW-1:0] vic_idx;
    logic [RW-1:0] vic_rank;
    logic [IW-1:0] free_idx;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign scan_en   = lag_en_reg && ((state_reg == ST_SCAN) || (state_reg == ST_SCAN_END));
    assign upd_phase = lag_en_reg && ((state_reg == ST_UPD) || (state_reg == ST_UPD_END));

    lfu_store #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .RW       (RW)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_en        (rd_en),
        .rd_idx       (idx_reg),
        .rd_rec       (rd_rec),
        .rd_rank      (rd_rank),
        .rd_valid     (rd_valid),
        .wr_en        (wr_en),
        .wr_idx       (lag_idx_reg),
        .wr_rec       (wr_rec),
        .wr_rank      (wr_rank),
        .wr_set_valid (wr_set_valid)
    );

    lfu_scan #(
        .IW (IW),
        .RW (RW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clr         (accept),
        .en          (scan_en),
        .slot_idx    (lag_idx_reg),
        .slot_valid  (rd_valid),
        .slot_rec    (rd_rec),
        .slot_rank   (rd_rank),
        .key         (cmd_reg.lookup_key),
        .flags       (flags),
        .match_idx   (match_idx),
        .match_value (match_value),
        .match_rank  (match_rank),
        .vic_idx     (vic_idx),
        .vic_rank    (vic_rank),
        .free_idx    (free_idx)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = ST_SCAN_END;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_SCAN_END:
                state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                idx_next = '0;
                if (op_next == OP_NONE)
                    state_next = ST_IDLE;
                else
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                rd_en = 1'b1;
                if (idx_reg == LAST_IDX)
                    state_next = ST_UPD_END;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_UPD_END:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // decision after the scan
    always_comb
    begin
        cap_eff     = (CW'(capacity_reg) > CAP_MAX) ? CAP_MAX : CW'(capacity_reg);
        filled_wide = CW'(filled_reg);
        op_next       = OP_NONE;
        target_next   = target_reg;
        ref_rank_next = ref_rank_reg;
        if (flags.match_found)
        begin
            op_next       = OP_HIT;
            target_next   = match_idx;
            ref_rank_next = match_rank;
        end
        else if ((cmd_reg.action == ACT_SET) && (cap_eff != '0))
        begin
            if (filled_wide >= cap_eff)
            begin
                if (flags.vic_found)
                begin
                    op_next       = OP_INS_EVICT;
                    target_next   = vic_idx;
                    ref_rank_next = vic_rank;
                end
            end
            else if (flags.free_found)
            begin
                op_next     = OP_INS_FREE;
                target_next = free_idx;
            end
        end
    end

    // read-modify-write of one slot during the update sweep
    always_comb
    begin
        wr_rec       = rd_rec;
        wr_rank      = rd_rank;
        wr_set_valid = 1'b0;
        wr_en        = upd_phase && ((lag_idx_reg == target_reg) || rd_valid);
        if (lag_idx_reg == target_reg)
        begin
            wr_rank      = '0;
            wr_set_valid = 1'b1;
            if (op_reg == OP_HIT)
            begin
                if (cmd_reg.action == ACT_SET)
                    wr_rec.value = cmd_reg.store_value;
                if (!(&rd_rec.count))
                    wr_rec.count = rd_rec.count + 32'd1;
            end
            else
            begin
                wr_rec.key   = cmd_reg.lookup_key;
                wr_rec.value = cmd_reg.store_value;
                wr_rec.count = 32'd1;
            end
        end
        else
        begin
            case (op_reg)
                OP_HIT:
                    if (rd_rank < ref_rank_reg)
                        wr_rank = rd_rank + 1'b1;
                OP_INS_EVICT:
                    if (!(rd_rank > ref_rank_reg))
                        wr_rank = rd_rank + 1'b1;
                OP_INS_FREE:
                    wr_rank = rd_rank + 1'b1;
                default:
                    wr_rank = rd_rank;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            lag_en_reg    <= 1'b0;
            capacity_reg  <= 5'd16;
            filled_reg    <= '0;
            op_reg        <= OP_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            lag_en_reg    <= rd_en;
            res_valid_reg <= (state_reg == ST_DECIDE) && (cmd_reg.action == ACT_GET);
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            if (state_reg == ST_DECIDE)
            begin
                op_reg <= op_next;
                if (op_next == OP_INS_FREE)
                    filled_reg <= filled_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lag_idx_reg <= idx_reg;
        if (accept)
            cmd_reg <= cmd;
        if (state_reg == ST_DECIDE)
        begin
            target_reg   <= target_next;
            ref_rank_reg <= ref_rank_next;
            res_reg.hit  <= flags.match_found;
            res_reg.read_value <= flags.match_found ? match_value : 32'hFFFF_FFFF;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_NEXT(a_one_result, clk, rst_n, res_valid, !res_valid)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy)
    `ASSERT_NEXT(a_result_after_decide, clk, rst_n, (state_reg == ST_DECIDE) && (cmd_reg.action == ACT_GET), res_valid)
    `ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, CW'(filled_reg) <= CAP_MAX)

endmodule
